// File: hw/rtl/usbdr_pkg.sv
// Shared types, constants and descriptor tables of the USB descriptor request responder.
// Used by the front classifier, the command queue and the back reply streamer.
`default_nettype none

package usbdr_pkg;

   // Reply status codes.
   localparam logic [1:0] ST_DATA  = 2'd0;
   localparam logic [1:0] ST_STALL = 2'd1;
   localparam logic [1:0] ST_ACK   = 2'd2;

   // Request codes and descriptor types.
   localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
   localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
   localparam logic [7:0] DT_DEVICE             = 8'd1;
   localparam logic [7:0] DT_CONFIG             = 8'd2;
   localparam logic [7:0] DT_STRING             = 8'd3;
   localparam logic [7:0] DT_QUALIFIER          = 8'd6;
   localparam logic [7:0] DT_OTHER_SPEED        = 8'd7;
   localparam logic [15:0] LANG_EN_US           = 16'h0409;
   localparam logic [7:0] NUM_STRINGS           = 8'd5;

   // Configuration register indexes.
   localparam logic [7:0] CSR_VENDOR_ID  = 8'd0;
   localparam logic [7:0] CSR_PRODUCT_ID = 8'd1;

   // Full reply lengths.
   localparam logic [5:0] LEN_DEVICE = 6'd18;
   localparam logic [5:0] LEN_CONFIG = 6'd32;
   localparam logic [5:0] LEN_STR0   = 6'd4;
   localparam logic [5:0] LEN_ONE    = 6'd1;

   // Source of the reply bytes.
   typedef enum logic [3:0] {
      SRC_NONE,
      SRC_DEVICE,
      SRC_CONFIG,
      SRC_STR0,
      SRC_STR1,
      SRC_STR2,
      SRC_STR3,
      SRC_STR4,
      SRC_ONE
   } src_type;

   // One classified request as it travels from front to back.
   typedef struct packed {
      src_type    src;
      logic [1:0] status;
      logic [5:0] len;
   } cmd_type;

   // Configuration bundle: configuration, interface and two interrupt endpoints.
   localparam logic [7:0] CFG_ROM [32] = '{
      8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h04, 8'hC0, 8'h01,
      8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h04,
      8'h07, 8'h05, 8'h81, 8'h03, 8'h40, 8'h00, 8'h0A,
      8'h07, 8'h05, 8'h01, 8'h03, 8'h40, 8'h00, 8'h0A
   };

   // String texts, left aligned in twelve characters.
   localparam logic [95:0] STR1_TEXT = "Manufacturer";
   localparam logic [95:0] STR2_TEXT = "Product     ";
   localparam logic [95:0] STR3_TEXT = "Serial      ";
   localparam logic [95:0] STR4_TEXT = "Loopback    ";

   // Number of characters in a string descriptor.
   function automatic logic [3:0] str_chars(input src_type src);
      logic [3:0] n;
      unique case (src)
         SRC_STR1: n = 4'd12;
         SRC_STR2: n = 4'd7;
         SRC_STR3: n = 4'd6;
         SRC_STR4: n = 4'd8;
         default:  n = 4'd0;
      endcase
      return n;
   endfunction

   // Character of a string descriptor text.
   function automatic logic [7:0] str_char(input src_type src, input logic [3:0] ci);
      logic [95:0] txt;
      logic [7:0]  c;
      unique case (src)
         SRC_STR1: txt = STR1_TEXT;
         SRC_STR2: txt = STR2_TEXT;
         SRC_STR3: txt = STR3_TEXT;
         default:  txt = STR4_TEXT;
      endcase
      if (ci < 4'd12) begin
         c = txt[8 * (11 - int'(ci)) +: 8];
      end else begin
         c = 8'd0;
      end
      return c;
   endfunction

   // Byte at a position of a reply.
   function automatic logic [7:0] rom_byte(input src_type src, input logic [4:0] pos,
                                           input logic [15:0] vid, input logic [15:0] pid);
      logic [7:0] b;
      b = 8'd0;
      unique case (src)
         SRC_DEVICE: begin
            unique case (pos)
               5'd0:    b = 8'h12;
               5'd1:    b = 8'h01;
               5'd3:    b = 8'h01;
               5'd4:    b = 8'hFF;
               5'd7:    b = 8'h40;
               5'd8:    b = vid[7:0];
               5'd9:    b = vid[15:8];
               5'd10:   b = pid[7:0];
               5'd11:   b = pid[15:8];
               5'd14:   b = 8'h01;
               5'd15:   b = 8'h02;
               5'd16:   b = 8'h03;
               5'd17:   b = 8'h01;
               default: b = 8'h00;
            endcase
         end
         SRC_CONFIG: b = CFG_ROM[pos];
         SRC_STR0: begin
            unique case (pos)
               5'd0:    b = 8'h04;
               5'd1:    b = 8'h03;
               5'd2:    b = LANG_EN_US[7:0];
               5'd3:    b = LANG_EN_US[15:8];
               default: b = 8'h00;
            endcase
         end
         SRC_STR1, SRC_STR2, SRC_STR3, SRC_STR4: begin
            if (pos == 5'd0) begin
               b = {3'd0, str_chars(src), 1'b0} + 8'd2;
            end else if (pos == 5'd1) begin
               b = 8'h03;
            end else if (!pos[0]) begin
               b = str_char(src, pos[4:1] - 4'd1);
            end else begin
               b = 8'h00;
            end
         end
         SRC_ONE:  b = 8'h01;
         default:  b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/usbdr_front.sv
// Front end of the USB descriptor request responder: classifies one setup packet
// into a reply command. Depends on usbdr_pkg.
`default_nettype none

module usbdr_front
   import usbdr_pkg::*;
(
   input  wire logic [7:0]  request_type,
   input  wire logic [7:0]  request_code,
   input  wire logic [15:0] request_value,
   input  wire logic [15:0] request_index,
   input  wire logic [15:0] request_length,
   output cmd_type          cmd
);

   logic [7:0] dtype;
   logic [7:0] didx;
   src_type    src;
   logic [1:0] status;
   logic [5:0] full_len;
   logic [5:0] cut_len;

   assign dtype = request_value[15:8];
   assign didx  = request_value[7:0];

   // Decode the request into a reply source or a single status item.
   always_comb begin
      src      = SRC_NONE;
      status   = ST_ACK;
      full_len = 6'd0;
      if (!request_type[7]) begin
         status = ST_ACK;
      end else if (request_code == REQ_GET_DESCRIPTOR) begin
         if (dtype == DT_DEVICE) begin
            src      = SRC_DEVICE;
            status   = ST_DATA;
            full_len = LEN_DEVICE;
         end else if (dtype == DT_CONFIG) begin
            if (didx != 8'd0) begin
               status = ST_STALL;
            end else begin
               src      = SRC_CONFIG;
               status   = ST_DATA;
               full_len = LEN_CONFIG;
            end
         end else if (dtype == DT_STRING) begin
            if (didx != 8'd0 && request_index != LANG_EN_US) begin
               status = ST_STALL;
            end else if (didx >= NUM_STRINGS) begin
               status = ST_STALL;
            end else begin
               status = ST_DATA;
               src    = src_type'(4'(SRC_STR0) + didx[3:0]);
               if (didx == 8'd0) begin
                  full_len = LEN_STR0;
               end else begin
                  full_len = {1'b0, str_chars(src), 1'b0} + 6'd2;
               end
            end
         end else if (dtype == DT_QUALIFIER || dtype == DT_OTHER_SPEED) begin
            status = ST_STALL;
         end else begin
            status = ST_ACK;
         end
      end else if (request_code == REQ_GET_CONFIGURATION ||
                   request_code == REQ_GET_INTERFACE) begin
         src      = SRC_ONE;
         status   = ST_DATA;
         full_len = LEN_ONE;
      end else begin
         status = ST_ACK;
      end
   end

   // Cut the reply to the host's length; an empty reply becomes an acknowledge.
   assign cut_len = (request_length < {10'd0, full_len}) ? request_length[5:0] : full_len;

   always_comb begin
      cmd.src    = src;
      cmd.status = status;
      cmd.len    = 6'd1;
      if (status == ST_DATA) begin
         if (cut_len == 6'd0) begin
            cmd.src    = SRC_NONE;
            cmd.status = ST_ACK;
         end else begin
            cmd.len = cut_len;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/usbdr_queue.sv
// Short command queue between the front classifier and the back reply streamer.
// Depends on usbdr_pkg for the command type.
`default_nettype none

module usbdr_queue
   import usbdr_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         not_empty,
   output logic         full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command queue read while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue count did not advance on a push");

endmodule

`default_nettype wire

// File: hw/rtl/usbdr_back.sv
// Back end of the USB descriptor request responder: streams reply bytes of one
// command per cycle from the descriptor tables. Depends on usbdr_pkg.
`default_nettype none

module usbdr_back
   import usbdr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     head_cmd,
   input  wire logic        not_empty,
   output logic             pop,
   input  wire logic [15:0] vendor_id,
   input  wire logic [15:0] product_id,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last_byte
);

   typedef enum logic [1:0] {
      IDLE = 2'b01,
      RUN  = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   logic [4:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       last_now;

   // The final item of the current command is formed this cycle and registered to the outputs.
   assign last_now = (state_ff == RUN) && (({1'b0, pos_ff} + 6'd1) == cmd_ff.len);
   assign pop      = not_empty && ((state_ff == IDLE) || last_now);

   // Sequencer: load a command, then step through its bytes.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      pos_in   = pos_ff;
      if (pop) begin
         state_in = RUN;
         cmd_in   = head_cmd;
         pos_in   = 5'd0;
      end else if (last_now) begin
         state_in = IDLE;
      end else if (state_ff == RUN) begin
         pos_in = pos_ff + 5'd1;
      end
   end

   // Result item for the current position.
   always_comb begin
      rsp_valid_in  = (state_ff == RUN);
      rsp_status_in = cmd_ff.status;
      rsp_last_in   = last_now;
      rsp_data_in   = 8'd0;
      if (cmd_ff.status == ST_DATA) begin
         rsp_data_in = rom_byte(cmd_ff.src, pos_ff, vendor_id, product_id);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_last_byte = rsp_last_ff;

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DATA) |-> rsp_last_byte)
      else $error("stall or acknowledge result without last flag");

   a_run_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |=> rsp_valid)
      else $error("running sequencer produced no result");

   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |=> !rsp_valid)
      else $error("result produced while sequencer idle");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |-> (({1'b0, pos_ff}) < cmd_ff.len))
      else $error("reply position beyond command length");

endmodule

`default_nettype wire

// File: hw/rtl/usb_descriptor_request_responder.sv
// Top level of the USB descriptor request responder: configuration registers,
// front classifier, command queue and back reply streamer. Depends on usbdr_pkg.
//
// Usage:
//   A setup packet is presented on the req_ ports and taken at a clock edge where
//   start is high and busy is low. busy is high while the command queue is full.
//   Replies leave on the rsp_ ports, one result per cycle marked by rsp_valid;
//   rsp_last_byte marks the final result of a request. The receiver cannot hold
//   results off, so every rsp_valid cycle is a completed transaction.
//   A data reply gives one result per byte (at most 32); a stall or acknowledge
//   gives a single result.
// Flow and throughput:
//   When the streamer is free, an accepted request is written into the command queue,
//   loaded into the streamer's command register, and its first result is then
//   registered onto the rsp_ ports. The streamer loads the next queued command in
//   the cycle in which it forms the last result of a request, so replies follow
//   each other without gaps. The one-byte-per-cycle streamer sets the rate.
// Reset:
//   reset is synchronous and active high. It empties the queue, stops the streamer
//   and sets vendor_id and product_id to 0xFFFF. Registers are written over the
//   csr_ port, which is always ready; writes are meant for idle periods only.
`default_nettype none

module usb_descriptor_request_responder
   import usbdr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_request_type,
   input  wire logic [7:0]  req_request_code,
   input  wire logic [15:0] req_request_value,
   input  wire logic [15:0] req_request_index,
   input  wire logic [15:0] req_request_length,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last_byte,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [15:0] vendor_id_ff, vendor_id_in;
   logic [15:0] product_id_ff, product_id_in;
   cmd_type     front_cmd;
   cmd_type     head_cmd;
   logic        accept;
   logic        pop;
   logic        not_empty;
   logic        full;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      vendor_id_in  = vendor_id_ff;
      product_id_in = product_id_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_VENDOR_ID) begin
            vendor_id_in = csr_data;
         end else if (csr_index == CSR_PRODUCT_ID) begin
            product_id_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_id_ff  <= 16'hFFFF;
         product_id_ff <= 16'hFFFF;
      end else begin
         vendor_id_ff  <= vendor_id_in;
         product_id_ff <= product_id_in;
      end
   end

   // Request acceptance.
   assign busy   = full;
   assign accept = start && !busy;

   usbdr_front u_front (
      .request_type   (req_request_type),
      .request_code   (req_request_code),
      .request_value  (req_request_value),
      .request_index  (req_request_index),
      .request_length (req_request_length),
      .cmd            (front_cmd)
   );

   usbdr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (not_empty),
      .full      (full)
   );

   usbdr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .not_empty     (not_empty),
      .pop           (pop),
      .vendor_id     (vendor_id_ff),
      .product_id    (product_id_ff),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the USB descriptor request responder.
// It needs the RTL top level and usbdr_pkg; it predicts every reply byte from the setup
// packet and the vendor and product ID registers, then checks each reply transaction.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import usbdr_pkg::*;

   localparam int          CLOCK_HALF  = 6;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          PHASE_ITEMS = 160;
   localparam logic [7:0]  RT_STD_IN   = 8'h80;
   localparam logic [7:0]  RT_STD_OUT  = 8'h00;
   localparam logic [15:0] LEN_ALL     = 16'hFFFF;

   // One setup packet, plus a flag that makes the sender wait until all replies are in.
   typedef struct {
      logic [7:0]  rtype;
      logic [7:0]  code;
      logic [15:0] value;
      logic [15:0] windex;
      logic [15:0] wlength;
      bit          drain_first;
   } setup_type;

   // One reply transaction.
   typedef struct {
      logic [1:0] status;
      logic [7:0] data;
      logic       last;
   } reply_type;

   // Configuration bundle: configuration, interface and two interrupt endpoints.
   localparam logic [7:0] CONFIG_BUNDLE [32] = '{
      8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h04, 8'hC0, 8'h01,
      8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h04,
      8'h07, 8'h05, 8'h81, 8'h03, 8'h40, 8'h00, 8'h0A,
      8'h07, 8'h05, 8'h01, 8'h03, 8'h40, 8'h00, 8'h0A
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_request_type = 8'd0;
   logic [7:0]  req_request_code = 8'd0;
   logic [15:0] req_request_value = 16'd0;
   logic [15:0] req_request_index = 16'd0;
   logic [15:0] req_request_length = 16'd0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'd0;
   logic [15:0] csr_data = 16'd0;

   setup_type   pending_setups[$];
   reply_type   expected_replies[$];
   logic [15:0] vendor_id_copy = 16'hFFFF;
   logic [15:0] product_id_copy = 16'hFFFF;
   int          sender_idle_pct = 13;
   int          offered_count = 0;
   int          accepted_count = 0;
   int          error_count = 0;
   int          cycle_count = 0;

   usb_descriptor_request_responder u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_request_type   (req_request_type),
      .req_request_code   (req_request_code),
      .req_request_value  (req_request_value),
      .req_request_index  (req_request_index),
      .req_request_length (req_request_length),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_byte      (rsp_last_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Print one mismatch and count it.
   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Text of string descriptors 1 to 4.
   function automatic string string_text(input logic [7:0] idx);
      string txt;
      case (idx)
         8'd1:    txt = "Manufacturer";
         8'd2:    txt = "Product";
         8'd3:    txt = "Serial";
         default: txt = "Loopback";
      endcase
      return txt;
   endfunction

   // Work out the reply transactions of one setup packet and queue them.
   function automatic void predict_reply(input logic [7:0] rtype, input logic [7:0] code,
                                         input logic [15:0] value, input logic [15:0] windex,
                                         input logic [15:0] wlength);
      logic [7:0] desc_bytes [32];
      logic [7:0] dtype;
      logic [7:0] didx;
      logic [1:0] single_status;
      bit         is_single;
      int         n;
      string      txt;
      reply_type  r;

      dtype = value[15:8];
      didx = value[7:0];
      is_single = 1'b1;
      single_status = ST_ACK;
      n = 0;
      foreach (desc_bytes[i]) desc_bytes[i] = 8'h00;

      if (rtype[7]) begin
         if (code == REQ_GET_DESCRIPTOR) begin
            case (dtype)
               DT_DEVICE: begin
                  desc_bytes[0] = 8'h12;
                  desc_bytes[1] = 8'h01;
                  desc_bytes[3] = 8'h01;
                  desc_bytes[4] = 8'hFF;
                  desc_bytes[7] = 8'h40;
                  desc_bytes[8] = vendor_id_copy[7:0];
                  desc_bytes[9] = vendor_id_copy[15:8];
                  desc_bytes[10] = product_id_copy[7:0];
                  desc_bytes[11] = product_id_copy[15:8];
                  desc_bytes[14] = 8'h01;
                  desc_bytes[15] = 8'h02;
                  desc_bytes[16] = 8'h03;
                  desc_bytes[17] = 8'h01;
                  n = 18;
                  is_single = 1'b0;
               end
               DT_CONFIG: begin
                  if (didx != 8'd0) begin
                     single_status = ST_STALL;
                  end else begin
                     foreach (CONFIG_BUNDLE[i]) desc_bytes[i] = CONFIG_BUNDLE[i];
                     n = 32;
                     is_single = 1'b0;
                  end
               end
               DT_STRING: begin
                  // String 0 is the language table and is given for any language.
                  if ((didx != 8'd0 && windex != LANG_EN_US) || didx >= NUM_STRINGS) begin
                     single_status = ST_STALL;
                  end else if (didx == 8'd0) begin
                     desc_bytes[0] = 8'h04;
                     desc_bytes[1] = 8'h03;
                     desc_bytes[2] = LANG_EN_US[7:0];
                     desc_bytes[3] = LANG_EN_US[15:8];
                     n = 4;
                     is_single = 1'b0;
                  end else begin
                     txt = string_text(didx);
                     n = 2 + 2 * txt.len();
                     desc_bytes[0] = 8'(n);
                     desc_bytes[1] = 8'h03;
                     for (int i = 0; i < txt.len(); i++) begin
                        desc_bytes[2 + 2 * i] = txt[i];
                     end
                     is_single = 1'b0;
                  end
               end
               DT_QUALIFIER, DT_OTHER_SPEED: single_status = ST_STALL;
               default: single_status = ST_ACK;
            endcase
         end else if (code == REQ_GET_CONFIGURATION || code == REQ_GET_INTERFACE) begin
            desc_bytes[0] = 8'h01;
            n = 1;
            is_single = 1'b0;
         end
      end

      // The reply is cut to wLength; nothing left means a plain acknowledge.
      if (!is_single) begin
         if (n > int'(wlength)) n = int'(wlength);
         if (n == 0) is_single = 1'b1;
      end

      if (is_single) begin
         r.status = single_status;
         r.data = 8'h00;
         r.last = 1'b1;
         expected_replies.push_back(r);
      end else begin
         for (int i = 0; i < n; i++) begin
            r.status = ST_DATA;
            r.data = desc_bytes[i];
            r.last = (i == n - 1);
            expected_replies.push_back(r);
         end
      end
   endfunction

   function automatic setup_type make_setup(input logic [7:0] rtype, input logic [7:0] code,
                                            input logic [15:0] value,
                                            input logic [15:0] windex,
                                            input logic [15:0] wlength);
      setup_type s;
      s.rtype = rtype;
      s.code = code;
      s.value = value;
      s.windex = windex;
      s.wlength = wlength;
      s.drain_first = 1'b0;
      return s;
   endfunction

   // Mostly short lengths so that cutting is common, with zero and full lengths mixed in.
   function automatic logic [15:0] random_length();
      int pick;
      logic [15:0] len;
      pick = $urandom_range(9);
      if (pick == 0) len = 16'd0;
      else if (pick <= 5) len = 16'($urandom_range(40));
      else if (pick == 6) len = LEN_ALL;
      else if (pick <= 8) len = 16'($urandom);
      else len = 16'($urandom_range(3, 1));
      return len;
   endfunction

   // Mostly well-formed requests with random content; the rest is noise.
   function automatic setup_type random_setup();
      setup_type s;
      int pick;
      int kind;
      logic [7:0] dtype;
      logic [7:0] didx;

      pick = $urandom_range(99);
      s.rtype = {1'b1, 7'($urandom)};
      s.value = 16'($urandom);
      s.windex = ($urandom_range(4) != 0) ? LANG_EN_US : 16'($urandom);
      s.wlength = random_length();
      if (pick < 55) begin
         s.code = REQ_GET_DESCRIPTOR;
         kind = $urandom_range(9);
         if (kind <= 1) dtype = DT_DEVICE;
         else if (kind <= 3) dtype = DT_CONFIG;
         else if (kind <= 6) dtype = DT_STRING;
         else if (kind == 7) dtype = DT_QUALIFIER;
         else if (kind == 8) dtype = DT_OTHER_SPEED;
         else dtype = 8'($urandom);
         if ($urandom_range(9) == 0) didx = 8'($urandom);
         else if (dtype == DT_CONFIG) didx = 8'($urandom_range(1));
         else didx = 8'($urandom_range(5));
         s.value = {dtype, didx};
      end else if (pick < 70) begin
         s.code = $urandom_range(1) ? REQ_GET_CONFIGURATION : REQ_GET_INTERFACE;
      end else begin
         s.rtype = 8'($urandom);
         s.code = 8'($urandom);
         s.windex = 16'($urandom);
         s.wlength = 16'($urandom);
      end
      s.drain_first = ($urandom_range(49) == 0);
      return s;
   endfunction

   // Write one configuration register through the csr_ channel.
   task automatic write_register(input logic [7:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_VENDOR_ID) vendor_id_copy = val;
      else if (idx == CSR_PRODUCT_ID) product_id_copy = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every setup packet is taken and every reply has arrived.
   task automatic wait_for_idle();
      while (pending_setups.size() != 0 || offered_count != accepted_count ||
             expected_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic run_random_phase(input int idle_pct);
      sender_idle_pct = idle_pct;
      repeat (PHASE_ITEMS) pending_setups.push_back(random_setup());
      wait_for_idle();
   endtask

   // Driver: offers the next setup packet at the falling edge and holds it until taken.
   always @(negedge clock) begin
      setup_type next_setup;
      if (reset) begin
         start <= 1'b0;
      end else if (offered_count == accepted_count) begin
         if (pending_setups.size() != 0 &&
             !(pending_setups[0].drain_first && expected_replies.size() != 0) &&
             $urandom_range(99) >= sender_idle_pct) begin
            next_setup = pending_setups.pop_front();
            start <= 1'b1;
            req_request_type <= next_setup.rtype;
            req_request_code <= next_setup.code;
            req_request_value <= next_setup.value;
            req_request_index <= next_setup.windex;
            req_request_length <= next_setup.wlength;
            offered_count++;
         end else begin
            // Idle cycle: the request ports carry junk that must be ignored.
            start <= 1'b0;
            req_request_type <= 8'($urandom);
            req_request_code <= 8'($urandom);
            req_request_value <= 16'($urandom);
            req_request_index <= 16'($urandom);
            req_request_length <= 16'($urandom);
         end
      end
   end

   // Monitor: checks each reply transaction, then records an accepted setup packet.
   always @(posedge clock) begin
      reply_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("unexpected reply status %0d data %02h last %0d",
                                         rsp_status, rsp_data_byte, rsp_last_byte));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
               if (rsp_data_byte !== want.data) begin
                  report_mismatch($sformatf("data byte %02h, expected %02h",
                                            rsp_data_byte, want.data));
               end
               if (rsp_last_byte !== want.last) begin
                  report_mismatch($sformatf("last byte flag %0d, expected %0d",
                                            rsp_last_byte, want.last));
               end
            end
         end
         if (start && !busy) begin
            predict_reply(req_request_type, req_request_code, req_request_value,
                          req_request_index, req_request_length);
            accepted_count++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed packets with the reset ID values.
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_DEVICE, 8'd0}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_DEVICE, 8'd0}, 16'd0, 16'd5));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_DEVICE, 8'd0}, 16'd0, 16'd0));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_CONFIG, 8'd0}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_CONFIG, 8'd0}, 16'd0, 16'd9));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_CONFIG, 8'd1}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_CONFIG, 8'hFF}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_STRING, 8'd0}, 16'd0, 16'd255));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_STRING, 8'd0}, 16'hFFFF, LEN_ALL));
      for (int i = 1; i <= 4; i++) begin
         pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                             {DT_STRING, 8'(i)}, LANG_EN_US, LEN_ALL));
      end
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_STRING, 8'd5}, LANG_EN_US, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_STRING, 8'd2}, 16'h0407, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_QUALIFIER, 8'd0}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          {DT_OTHER_SPEED, 8'd0}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_DESCRIPTOR,
                                          16'hFFFF, 16'hFFFF, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_CONFIGURATION,
                                          16'd0, 16'd0, 16'd1));
      pending_setups.push_back(make_setup(RT_STD_IN, REQ_GET_INTERFACE,
                                          16'd0, 16'd0, 16'd0));
      pending_setups.push_back(make_setup(8'hFF, REQ_GET_INTERFACE,
                                          16'hFFFF, 16'hFFFF, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_OUT, REQ_GET_DESCRIPTOR,
                                          {DT_DEVICE, 8'd0}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(RT_STD_IN, 8'hFF,
                                          {DT_DEVICE, 8'd0}, 16'd0, LEN_ALL));
      pending_setups.push_back(make_setup(8'h7F, 8'd0, 16'd0, 16'd0, 16'd0));
      wait_for_idle();

      // Random phases, each under its own ID values and sender idling.
      write_register(CSR_VENDOR_ID, 16'h0000);
      write_register(CSR_PRODUCT_ID, 16'hFFFF);
      run_random_phase(13);

      write_register(CSR_VENDOR_ID, 16'($urandom));
      write_register(CSR_PRODUCT_ID, 16'($urandom));
      run_random_phase(74);

      write_register(CSR_VENDOR_ID, 16'hFFFF);
      write_register(CSR_PRODUCT_ID, 16'h0000);
      run_random_phase(0);

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
